>>> hdl/assert_macros.svh
// Assertion macros shared by the queue and back-part modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define FBMP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When pre holds, post must hold on the following clock.
`define FBMP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/fbmp_pkg.sv
// Shared types, constants and functions of the FFT bin magnitude and phase block.
package fbmp_pkg;

  localparam int MAX_FRAME_LOG2_DEF = 12;
  localparam int SAMPLE_WIDTH_DEF   = 24;

  localparam int CFG_IDX_W = 3;
  localparam int LOG2_W    = 4;
  localparam int MODE_W    = 3;
  localparam int DB_W      = 16;
  localparam int SPEC_W    = 57;
  localparam int PHASE_W   = 16;
  localparam int DBV_W     = 20;
  localparam int QDEPTH    = 2;

  localparam int CORDIC_STEPS = 21;
  localparam int LOG_STEPS    = 16;
  localparam int PI_Q20       = 3294199;
  localparam int DB_PER_LOG2  = 197284;
  localparam int DB_SPAN      = 30720;

  localparam logic signed [PHASE_W-1:0] PI_Q13   = 16'sd25736;
  localparam logic signed [SPEC_W-1:0]  SPEC_MAX = 57'h00FFFFFFFFFFFFFF;

  localparam logic [LOG2_W-1:0]      RST_FRAME_LOG2 = 4'd9;
  localparam logic [MODE_W-1:0]      RST_MAG_MODE   = 3'd1;
  localparam logic                   RST_PHASE_EN   = 1'b0;
  localparam logic signed [DB_W-1:0] RST_DBP_NORM   = 16'sd23117;
  localparam logic signed [DB_W-1:0] RST_MIN_DBP    = -16'sd26112;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LOG2 = 3'd0,
    CFG_MAG_MODE   = 3'd1,
    CFG_PHASE_EN   = 3'd2,
    CFG_DBP_NORM   = 3'd3,
    CFG_MIN_DBP    = 3'd4
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 3'd0,
    MODE_MAG   = 3'd1,
    MODE_MAG_N = 3'd2,
    MODE_POW   = 3'd3,
    MODE_POW_N = 3'd4,
    MODE_DB    = 3'd5
  } mode_t;

  typedef struct packed {
    logic is_edge;
    logic frame_end;
    logic run_end;
  } job_ctl_t;

  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] a;
    case (i)
      5'd0:    a = 20'd823550;
      5'd1:    a = 20'd486170;
      5'd2:    a = 20'd256879;
      5'd3:    a = 20'd130396;
      5'd4:    a = 20'd65451;
      5'd5:    a = 20'd32757;
      5'd6:    a = 20'd16383;
      5'd7:    a = 20'd8192;
      default: a = 20'd1 << (5'd20 - i);
    endcase
    return a;
  endfunction

  function automatic logic signed [SPEC_W-1:0] db_sat(input logic signed [DBV_W-1:0] v);
    logic signed [SPEC_W-1:0] r;
    if (v > DBV_W'(32767)) begin
      r = SPEC_W'(32767);
    end else if (v < -DBV_W'(32768)) begin
      r = -SPEC_W'(32768);
    end else begin
      r = SPEC_W'(v);
    end
    return r;
  endfunction

endpackage

>>> hdl/fbmp_queue.sv
// Small first-word-fall-through queue of jobs between the front and back parts.
`include "assert_macros.svh"

module fbmp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fbmp_pkg::QDEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= din;
    end
  end

  `FBMP_ASSERT(a_no_push_full, !(push && full), "job pushed into a full queue")
  `FBMP_ASSERT(a_no_pop_empty, !(pop && empty), "job taken from an empty queue")

endmodule

>>> hdl/fbmp_front.sv
// Front part: accepts value pairs, tracks the frame and issues one or two jobs per item.
module fbmp_front #(
  parameter int MAX_FRAME_LOG2 = fbmp_pkg::MAX_FRAME_LOG2_DEF,
  parameter int SAMPLE_WIDTH   = fbmp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fbmp_pkg::LOG2_W-1:0]      l_eff,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_first_value,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_second_value,
  output logic                             q_push,
  input  logic                             q_full,
  output logic [MAX_FRAME_LOG2-1:0]        q_bin,
  output logic signed [SAMPLE_WIDTH-1:0]   q_x,
  output logic signed [SAMPLE_WIDTH-1:0]   q_y,
  output fbmp_pkg::job_ctl_t               q_ctl
);

  localparam int MFL = MAX_FRAME_LOG2;
  localparam int SW  = SAMPLE_WIDTH;

  logic [MFL-2:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0]  held_r, held_nxt;
  logic                  pend_r, pend_nxt;
  logic [MFL-1:0]        pend_bin_r, pend_bin_nxt;
  logic [MFL-1:0]        half;
  logic                  last_bin;
  logic                  accept;

  assign half     = MFL'(1) << (l_eff - 1'b1);
  assign last_bin = (MFL'(cnt_r) >= (half - 1'b1));
  assign in_full  = pend_r | q_full;
  assign accept   = in_push & ~in_full;

  always_comb begin
    cnt_nxt      = cnt_r;
    held_nxt     = held_r;
    pend_nxt     = pend_r;
    pend_bin_nxt = pend_bin_r;
    q_push       = 1'b0;
    q_bin        = MFL'(cnt_r);
    q_x          = in_first_value;
    q_y          = in_second_value;
    q_ctl        = '{is_edge: 1'b0, frame_end: 1'b0, run_end: 1'b1};
    if (pend_r) begin
      q_push = ~q_full;
      q_bin  = pend_bin_r;
      q_x    = held_r;
      q_y    = '0;
      q_ctl  = '{is_edge: 1'b1, frame_end: 1'b1, run_end: 1'b1};
      if (!q_full) begin
        pend_nxt = 1'b0;
      end
    end else if (accept) begin
      q_push = 1'b1;
      if (cnt_r == '0) begin
        q_y      = '0;
        q_ctl    = '{is_edge: 1'b1, frame_end: 1'b0, run_end: 1'b1};
        held_nxt = in_second_value;
        cnt_nxt  = (MFL-1)'(1);
      end else if (last_bin) begin
        q_ctl        = '{is_edge: 1'b0, frame_end: 1'b0, run_end: 1'b0};
        pend_nxt     = 1'b1;
        pend_bin_nxt = half;
        cnt_nxt      = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      held_r <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_bin_r <= pend_bin_nxt;
  end

endmodule

>>> hdl/fbmp_back.sv
// Back part: squares, square root, log2, power scaling and CORDIC phase for one job at a time.
`include "assert_macros.svh"

module fbmp_back #(
  parameter int MAX_FRAME_LOG2 = fbmp_pkg::MAX_FRAME_LOG2_DEF,
  parameter int SAMPLE_WIDTH   = fbmp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [fbmp_pkg::LOG2_W-1:0]            l_eff,
  input  logic [fbmp_pkg::MODE_W-1:0]            mag_mode,
  input  logic                                   phase_enable,
  input  logic signed [fbmp_pkg::DB_W-1:0]       dbp_norm,
  input  logic signed [fbmp_pkg::DB_W-1:0]       min_dbp,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic [MAX_FRAME_LOG2-1:0]              q_bin,
  input  logic signed [SAMPLE_WIDTH-1:0]         q_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         q_y,
  input  fbmp_pkg::job_ctl_t                     q_ctl,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic [MAX_FRAME_LOG2-1:0]              out_bin_index,
  output logic signed [fbmp_pkg::SPEC_W-1:0]     out_spectral_value,
  output logic signed [fbmp_pkg::PHASE_W-1:0]    out_phase_angle,
  output logic                                   out_frame_end,
  output logic                                   out_run_end
);

  localparam int MFL  = MAX_FRAME_LOG2;
  localparam int SW   = SAMPLE_WIDTH;
  localparam int SW2  = 2 * SW;
  localparam int RW   = SW + 9 + MFL;
  localparam int RMW  = RW + 3;
  localparam int SQCW = $clog2(RW + 1);
  localparam int CW   = SW + 11;
  localparam int ZW   = 25;
  localparam int NW   = (SW2 < 32) ? 32 : SW2;
  localparam int PWD  = $clog2(NW);
  localparam int TW   = PWD + 18;
  localparam int DPW  = TW + 19;
  localparam int SPW  = fbmp_pkg::SPEC_W;
  localparam int VW   = fbmp_pkg::DBV_W;
  localparam int LW   = fbmp_pkg::LOG2_W;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SQX   = 11'b00000000010,
    ST_SQY   = 11'b00000000100,
    ST_SEL   = 11'b00000001000,
    ST_SQRT  = 11'b00000010000,
    ST_NORM  = 11'b00000100000,
    ST_LSQ   = 11'b00001000000,
    ST_LFIX  = 11'b00010000000,
    ST_DBMUL = 11'b00100000000,
    ST_DBFIN = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic signed [SW-1:0]        x_r, x_nxt;
  logic signed [SW-1:0]        y_r, y_nxt;
  logic [MFL-1:0]              bin_r, bin_nxt;
  fbmp_pkg::job_ctl_t          ctl_r, ctl_nxt;
  fbmp_pkg::mode_t             mode_r, mode_nxt;
  logic [LW-1:0]               lm_r, lm_nxt;
  logic [SW2-1:0]              acc_r, acc_nxt;
  logic [SW2-1:0]              sqs_r, sqs_nxt;
  logic [RW-1:0]               root_r, root_nxt;
  logic [RMW-1:0]              rem_r, rem_nxt;
  logic [SQCW-1:0]             sq_cnt_r, sq_cnt_nxt;
  logic [SQCW-1:0]             sq_len_r, sq_len_nxt;
  logic [NW-1:0]               nrm_r, nrm_nxt;
  logic [PWD-1:0]              p_r, p_nxt;
  logic [31:0]                 man_r, man_nxt;
  logic [63:0]                 msq_r, msq_nxt;
  logic [15:0]                 frac_r, frac_nxt;
  logic [4:0]                  lcnt_r, lcnt_nxt;
  logic signed [DPW-1:0]       dbp_r, dbp_nxt;
  logic signed [SPW-1:0]       spec_r, spec_nxt;
  logic signed [CW-1:0]        cx_r, cx_nxt;
  logic signed [CW-1:0]        cy_r, cy_nxt;
  logic signed [ZW-1:0]        cz_r, cz_nxt;
  logic [4:0]                  ci_r, ci_nxt;
  logic                        c_busy_r, c_busy_nxt;
  logic signed [fbmp_pkg::PHASE_W-1:0] ph_r, ph_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [MFL-1:0]              ob_r, ob_nxt;
  logic signed [SPW-1:0]       os_r, os_nxt;
  logic signed [fbmp_pkg::PHASE_W-1:0] op_r, op_nxt;
  logic                        ofe_r, ofe_nxt;
  logic                        ore_r, ore_nxt;

  logic [SW-1:0]               ax, ay, mul_in;
  logic [SW2-1:0]              sq;
  fbmp_pkg::mode_t             md;
  logic [LW:0]                 lsh2;
  logic [3:0]                  shl_k;
  logic [71:0]                 pw_sh;
  logic signed [SPW-1:0]       pw_val;
  logic [4:0]                  rs;
  logic [71:0]                 pn_sum, pn_shv;
  logic [1:0]                  two;
  logic [RMW-1:0]              remw, trial;
  logic [RW-1:0]               root_step;
  logic [RW:0]                 rootp1, root_sh;
  logic [32:0]                 lt;
  logic signed [TW-1:0]        tq;
  logic signed [DPW-1:0]       dbs;
  logic signed [VW-1:0]        normx, floor_a, minx, flo, dbv;
  logic signed [CW-1:0]        dx, dy, xs0, ys0;
  logic signed [ZW-1:0]        ca, cz_it, zr;

  assign ax     = x_r[SW-1] ? SW'(-x_r) : SW'(x_r);
  assign ay     = y_r[SW-1] ? SW'(-y_r) : SW'(y_r);
  assign mul_in = (state_r == ST_SQX) ? ax : ay;
  assign sq     = SW2'(mul_in) * SW2'(mul_in);

  assign lsh2   = {l_eff, 1'b0};
  assign shl_k  = (mode_r == fbmp_pkg::MODE_POW) ? 4'd8 : 4'(5'd8 - lsh2);
  assign pw_sh  = 72'(acc_r) << shl_k;
  assign pw_val = (|pw_sh[71:56]) ? fbmp_pkg::SPEC_MAX : SPW'(pw_sh[55:0]);
  assign rs     = lsh2 - 5'd8;
  assign pn_sum = 72'(acc_r) + (72'(1) << (rs - 1'b1));
  assign pn_shv = pn_sum >> rs;

  assign two       = sqs_r[SW2-1 -: 2];
  assign remw      = {rem_r[RMW-3:0], two};
  assign trial     = RMW'({root_r, 2'b01});
  assign root_step = {root_r[RW-2:0], (remw >= trial)};
  assign rootp1    = {1'b0, root_step} + 1'b1;
  assign root_sh   = rootp1 >> (lm_r + 1'b1);

  assign lt    = msq_r[63:31];
  assign tq    = TW'({p_r, frac_r}) - TW'({lsh2, 16'b0});
  assign dbs   = (dbp_r + DPW'(1 << 23)) >>> 24;
  assign normx = VW'(dbp_norm);
  assign minx  = VW'(min_dbp);
  assign floor_a = normx - VW'(fbmp_pkg::DB_SPAN);
  assign flo   = (minx < floor_a) ? floor_a : minx;
  assign dbv   = normx + VW'(dbs);

  assign dx    = cy_r >>> ci_r;
  assign dy    = cx_r >>> ci_r;
  assign ca    = ZW'(fbmp_pkg::atan_q20(ci_r));
  assign cz_it = cy_r[CW-1] ? (cz_r - ca) : (cz_r + ca);
  assign zr    = (cz_it + ZW'(64)) >>> 7;
  assign xs0   = (q_x[SW-1] ? -CW'(q_x) : CW'(q_x)) <<< 8;
  assign ys0   = (q_x[SW-1] ? -CW'(q_y) : CW'(q_y)) <<< 8;

  always_comb begin
    case (mag_mode)
      fbmp_pkg::MODE_MAG, fbmp_pkg::MODE_MAG_N, fbmp_pkg::MODE_POW,
      fbmp_pkg::MODE_POW_N, fbmp_pkg::MODE_DB: begin
        md = fbmp_pkg::mode_t'(mag_mode);
      end
      default: begin
        md = phase_enable ? fbmp_pkg::MODE_OFF : fbmp_pkg::MODE_MAG;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    bin_nxt    = bin_r;
    ctl_nxt    = ctl_r;
    mode_nxt   = mode_r;
    lm_nxt     = lm_r;
    acc_nxt    = acc_r;
    sqs_nxt    = sqs_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    sq_cnt_nxt = sq_cnt_r;
    sq_len_nxt = sq_len_r;
    nrm_nxt    = nrm_r;
    p_nxt      = p_r;
    man_nxt    = man_r;
    msq_nxt    = msq_r;
    frac_nxt   = frac_r;
    lcnt_nxt   = lcnt_r;
    dbp_nxt    = dbp_r;
    spec_nxt   = spec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    ci_nxt     = ci_r;
    c_busy_nxt = c_busy_r;
    ph_nxt     = ph_r;
    out_valid_nxt = out_valid_r;
    ob_nxt     = ob_r;
    os_nxt     = os_r;
    op_nxt     = op_r;
    ofe_nxt    = ofe_r;
    ore_nxt    = ore_r;
    q_pop      = 1'b0;

    if (c_busy_r) begin
      cx_nxt = cy_r[CW-1] ? (cx_r - dx) : (cx_r + dx);
      cy_nxt = cy_r[CW-1] ? (cy_r + dy) : (cy_r - dy);
      cz_nxt = cz_it;
      if (ci_r == 5'(fbmp_pkg::CORDIC_STEPS - 1)) begin
        c_busy_nxt = 1'b0;
        ph_nxt     = zr[fbmp_pkg::PHASE_W-1:0];
      end else begin
        ci_nxt = ci_r + 1'b1;
      end
    end

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          x_nxt    = q_x;
          y_nxt    = q_y;
          bin_nxt  = q_bin;
          ctl_nxt  = q_ctl;
          mode_nxt = md;
          cx_nxt   = xs0;
          cy_nxt   = ys0;
          ci_nxt   = '0;
          cz_nxt   = '0;
          if (q_x[SW-1]) begin
            cz_nxt = q_y[SW-1] ? -ZW'(fbmp_pkg::PI_Q20) : ZW'(fbmp_pkg::PI_Q20);
          end
          c_busy_nxt = phase_enable & ~q_ctl.is_edge & ~((q_x == '0) && (q_y == '0));
          ph_nxt     = '0;
          if (phase_enable && q_ctl.is_edge && q_x[SW-1]) begin
            ph_nxt = fbmp_pkg::PI_Q13;
          end
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        acc_nxt   = sq;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        acc_nxt   = acc_r + sq;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        case (mode_r)
          fbmp_pkg::MODE_MAG, fbmp_pkg::MODE_MAG_N: begin
            lm_nxt     = (mode_r == fbmp_pkg::MODE_MAG_N) ? l_eff : '0;
            sqs_nxt    = acc_r;
            root_nxt   = '0;
            rem_nxt    = '0;
            sq_cnt_nxt = '0;
            sq_len_nxt = SQCW'(SW + 9) +
                         SQCW'((mode_r == fbmp_pkg::MODE_MAG_N) ? l_eff : '0);
            state_nxt  = ST_SQRT;
          end
          fbmp_pkg::MODE_POW: begin
            spec_nxt  = pw_val;
            state_nxt = ST_DONE;
          end
          fbmp_pkg::MODE_POW_N: begin
            spec_nxt  = (l_eff <= LW'(4)) ? pw_val : SPW'(pn_shv[SPW-1:0]);
            state_nxt = ST_DONE;
          end
          fbmp_pkg::MODE_DB: begin
            if (acc_r == '0) begin
              spec_nxt  = fbmp_pkg::db_sat(flo);
              state_nxt = ST_DONE;
            end else begin
              nrm_nxt   = NW'(acc_r);
              p_nxt     = PWD'(NW - 1);
              state_nxt = ST_NORM;
            end
          end
          default: begin
            spec_nxt  = '0;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SQRT: begin
        sqs_nxt  = sqs_r << 2;
        root_nxt = root_step;
        if (remw >= trial) begin
          rem_nxt = remw - trial;
        end else begin
          rem_nxt = remw;
        end
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == sq_len_r - 1'b1) begin
          spec_nxt  = SPW'(root_sh);
          state_nxt = ST_DONE;
        end
      end
      ST_NORM: begin
        if (nrm_r[NW-1]) begin
          man_nxt   = nrm_r[NW-1 -: 32];
          frac_nxt  = '0;
          lcnt_nxt  = '0;
          state_nxt = ST_LSQ;
        end else begin
          nrm_nxt = nrm_r << 1;
          p_nxt   = p_r - 1'b1;
        end
      end
      ST_LSQ: begin
        msq_nxt   = man_r * man_r;
        state_nxt = ST_LFIX;
      end
      ST_LFIX: begin
        frac_nxt = {frac_r[14:0], lt[32]};
        man_nxt  = lt[32] ? lt[32:1] : lt[31:0];
        lcnt_nxt = lcnt_r + 1'b1;
        state_nxt = (lcnt_r == 5'(fbmp_pkg::LOG_STEPS - 1)) ? ST_DBMUL : ST_LSQ;
      end
      ST_DBMUL: begin
        dbp_nxt   = tq * $signed(19'(fbmp_pkg::DB_PER_LOG2));
        state_nxt = ST_DBFIN;
      end
      ST_DBFIN: begin
        spec_nxt  = fbmp_pkg::db_sat((dbv < flo) ? flo : dbv);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!c_busy_r && (!out_valid_r || out_pop)) begin
          out_valid_nxt = 1'b1;
          ob_nxt        = bin_r;
          os_nxt        = spec_r;
          op_nxt        = ph_r;
          ofe_nxt       = ctl_r.frame_end;
          ore_nxt       = ctl_r.run_end;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      c_busy_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_busy_r    <= c_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    bin_r    <= bin_nxt;
    ctl_r    <= ctl_nxt;
    mode_r   <= mode_nxt;
    lm_r     <= lm_nxt;
    acc_r    <= acc_nxt;
    sqs_r    <= sqs_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    sq_cnt_r <= sq_cnt_nxt;
    sq_len_r <= sq_len_nxt;
    nrm_r    <= nrm_nxt;
    p_r      <= p_nxt;
    man_r    <= man_nxt;
    msq_r    <= msq_nxt;
    frac_r   <= frac_nxt;
    lcnt_r   <= lcnt_nxt;
    dbp_r    <= dbp_nxt;
    spec_r   <= spec_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cz_r     <= cz_nxt;
    ci_r     <= ci_nxt;
    ph_r     <= ph_nxt;
    ob_r     <= ob_nxt;
    os_r     <= os_nxt;
    op_r     <= op_nxt;
    ofe_r    <= ofe_nxt;
    ore_r    <= ore_nxt;
  end

  assign out_empty          = ~out_valid_r;
  assign out_bin_index      = ob_r;
  assign out_spectral_value = os_r;
  assign out_phase_angle    = op_r;
  assign out_frame_end      = ofe_r;
  assign out_run_end        = ore_r;

  `FBMP_ASSERT(a_idle_cordic, (state_r != ST_IDLE) || !c_busy_r, "CORDIC busy with no job")
  `FBMP_ASSERT(a_sqrt_count, (state_r != ST_SQRT) || (sq_cnt_r < sq_len_r), "root overran")
  `FBMP_ASSERT_NEXT(a_done_wait,
    (state_r == ST_DONE) && (c_busy_r || (out_valid_r && !out_pop)),
    state_r == ST_DONE, "result left before the output slot was free")

endmodule

>>> hdl/fft_bin_magnitude_phase.sv
// Top level of the FFT bin magnitude and phase block: configuration registers and wiring.
//
//  Channel  Direction  Handshake        Payload
//  in_      in         in_push/in_full  first_value, second_value
//  out_     out        out_pop/out_empty bin_index, spectral_value, phase_angle, frame_end, run_end
//  cfg_     in         cfg_valid/ready  cfg_index, cfg_data
//
// A job leaves the queue, is squared and has its mode selected; power modes then deliver, magnitude
// modes run SAMPLE_WIDTH+9 (+L for magnitude/N) root steps, dB up to 2*SAMPLE_WIDTH normalize steps,
// log2 squaring steps, a multiply and a clamp; with phase on, delivery waits for the CORDIC.
// The back end handles one job at a time; the shift-subtract root sets the usual rate.
// Reset clears the control state and loads the register defaults; no clearing pass.
// Items enter while the two-entry job queue has room; a frame's last pair stalls input until its Nyquist job is queued.
module fft_bin_magnitude_phase #(
  parameter int MAX_FRAME_LOG2 = fbmp_pkg::MAX_FRAME_LOG2_DEF,
  parameter int SAMPLE_WIDTH   = fbmp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_first_value,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_second_value,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [MAX_FRAME_LOG2-1:0]            out_bin_index,
  output logic signed [fbmp_pkg::SPEC_W-1:0]   out_spectral_value,
  output logic signed [fbmp_pkg::PHASE_W-1:0]  out_phase_angle,
  output logic                                 out_frame_end,
  output logic                                 out_run_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fbmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbmp_pkg::DB_W-1:0]            cfg_data
);

  localparam int MFL = MAX_FRAME_LOG2;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int CTW = $bits(fbmp_pkg::job_ctl_t);
  localparam int JW  = MFL + 2 * SW + CTW;
  localparam int LW  = fbmp_pkg::LOG2_W;

  logic [LW-1:0]                     frame_log2_r;
  logic [fbmp_pkg::MODE_W-1:0]       mag_mode_r;
  logic                              phase_en_r;
  logic signed [fbmp_pkg::DB_W-1:0]  dbp_norm_r;
  logic signed [fbmp_pkg::DB_W-1:0]  min_dbp_r;
  logic [LW-1:0]                     l_eff;

  logic                  fq_push, fq_full, fq_pop, fq_empty;
  logic [JW-1:0]         fq_din, fq_dout;
  logic [MFL-1:0]        f_bin, b_bin;
  logic signed [SW-1:0]  f_x, f_y, b_x, b_y;
  fbmp_pkg::job_ctl_t    f_ctl, b_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_log2_r <= fbmp_pkg::RST_FRAME_LOG2;
      mag_mode_r   <= fbmp_pkg::RST_MAG_MODE;
      phase_en_r   <= fbmp_pkg::RST_PHASE_EN;
      dbp_norm_r   <= fbmp_pkg::RST_DBP_NORM;
      min_dbp_r    <= fbmp_pkg::RST_MIN_DBP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbmp_pkg::CFG_FRAME_LOG2: frame_log2_r <= cfg_data[LW-1:0];
        fbmp_pkg::CFG_MAG_MODE:   mag_mode_r   <= cfg_data[fbmp_pkg::MODE_W-1:0];
        fbmp_pkg::CFG_PHASE_EN:   phase_en_r   <= cfg_data[0];
        fbmp_pkg::CFG_DBP_NORM:   dbp_norm_r   <= cfg_data;
        fbmp_pkg::CFG_MIN_DBP:    min_dbp_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_log2_r < LW'(2)) begin
      l_eff = LW'(2);
    end else if ({1'b0, frame_log2_r} > (LW+1)'(MFL)) begin
      l_eff = LW'(MFL);
    end else begin
      l_eff = frame_log2_r;
    end
  end

  fbmp_front #(
    .MAX_FRAME_LOG2 (MFL),
    .SAMPLE_WIDTH   (SW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .l_eff           (l_eff),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .q_push          (fq_push),
    .q_full          (fq_full),
    .q_bin           (f_bin),
    .q_x             (f_x),
    .q_y             (f_y),
    .q_ctl           (f_ctl)
  );

  assign fq_din = {f_bin, f_x, f_y, f_ctl};

  fbmp_queue #(
    .W     (JW),
    .DEPTH (fbmp_pkg::QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_din),
    .full  (fq_full),
    .pop   (fq_pop),
    .dout  (fq_dout),
    .empty (fq_empty)
  );

  assign {b_bin, b_x, b_y, b_ctl} = fq_dout;

  fbmp_back #(
    .MAX_FRAME_LOG2 (MFL),
    .SAMPLE_WIDTH   (SW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .l_eff              (l_eff),
    .mag_mode           (mag_mode_r),
    .phase_enable       (phase_en_r),
    .dbp_norm           (dbp_norm_r),
    .min_dbp            (min_dbp_r),
    .q_empty            (fq_empty),
    .q_pop              (fq_pop),
    .q_bin              (b_bin),
    .q_x                (b_x),
    .q_y                (b_y),
    .q_ctl              (b_ctl),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_bin_index      (out_bin_index),
    .out_spectral_value (out_spectral_value),
    .out_phase_angle    (out_phase_angle),
    .out_frame_end      (out_frame_end),
    .out_run_end        (out_run_end)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the FFT bin magnitude and phase block.
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [11:0]                  bin;
    logic [fbmp_pkg::SPEC_W-1:0]  spec;
    logic [fbmp_pkg::PHASE_W-1:0] phase;
    logic                         fend;
    logic                         rend;
  } bin_result_t;

  typedef struct {
    int   a;
    int   b;
    bit   lit;
    longint spec;
  } row_t;

  typedef struct {
    int               log2n;
    fbmp_pkg::mode_t  mode;
    bit               ph;
    int               norm;
    int               floor_db;
    int               items;
  } setting_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_push = 1'b0;
  logic                                 in_full;
  logic signed [23:0]                   in_first_value = '0;
  logic signed [23:0]                   in_second_value = '0;
  logic                                 out_empty;
  logic                                 out_pop = 1'b0;
  logic [11:0]                          out_bin_index;
  logic signed [fbmp_pkg::SPEC_W-1:0]   out_spectral_value;
  logic signed [fbmp_pkg::PHASE_W-1:0]  out_phase_angle;
  logic                                 out_frame_end;
  logic                                 out_run_end;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [fbmp_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [fbmp_pkg::DB_W-1:0]            cfg_data = '0;

  bin_result_t bin_results_q[$];
  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = 13;
  int rx_idle_pct = 69;
  bit rx_hold = 1'b0;

  logic [3:0]  frame_log2;
  logic [2:0]  mag_mode;
  logic        phase_en;
  logic [15:0] dbp_norm;
  logic [15:0] min_dbp;
  logic [10:0] pair_cnt;
  logic [23:0] held_nyquist;

  bit [19:0] atan_tab[8] = '{20'd823550, 20'd486170, 20'd256879, 20'd130396,
                             20'd65451, 20'd32757, 20'd16383, 20'd8192};

  fft_bin_magnitude_phase u_dut (.*);

  always #6 clk = ~clk;

  function automatic bit [63:0] root_frac(bit [63:0] s, int f);
    bit [63:0] root = 0, rem = 0, two, trial;
    for (int g = 0; g < 32 + f; g++) begin
      two = (g < 32) ? ((s >> (62 - 2 * g)) & 64'd3) : 64'd0;
      rem = (rem << 2) | two;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic bit [63:0] log2_fix(bit [63:0] s);
    int p = 63;
    bit [63:0] m, frac = 0;
    while (p > 0 && !s[p]) p--;
    m = (p >= 31) ? (s >> (p - 31)) : (s << (31 - p));
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(p) << 16) + frac;
  endfunction

  function automatic bit [63:0] sra64(bit [63:0] u, int sh);
    return $signed(u) >>> sh;
  endfunction

  function automatic logic [15:0] bin_angle(longint x, longint y);
    longint base = 0;
    bit [63:0] xs, ys, z = 0, a, dx, dy;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      base = (y >= 0) ? fbmp_pkg::PI_Q20 : -fbmp_pkg::PI_Q20;
      x = -x;
      y = -y;
    end
    xs = x << 8;
    ys = y << 8;
    for (int i = 0; i <= 20; i++) begin
      a = (i < 8) ? 64'(atan_tab[i]) : (64'd1 << (20 - i));
      dx = sra64(ys, i);
      dy = sra64(xs, i);
      if (ys[63]) begin
        xs = xs - dx;
        ys = ys + dy;
        z = z - a;
      end else begin
        xs = xs + dx;
        ys = ys - dy;
        z = z + a;
      end
    end
    z = z + 64'(base);
    return 16'(sra64(z + 64'd64, 7));
  endfunction

  function automatic logic [fbmp_pkg::SPEC_W-1:0] level_of(bit [63:0] s, logic [2:0] mode,
                                                           int l2);
    int sh = 2 * l2;
    bit [63:0] smax = 64'h00FF_FFFF_FFFF_FFFF;
    longint norm, flo, v, t;
    bit [63:0] u;
    case (mode)
      fbmp_pkg::MODE_MAG: return (root_frac(s, 9) + 1) >> 1;
      fbmp_pkg::MODE_MAG_N: return (root_frac(s, 9 + l2) + 1) >> (l2 + 1);
      fbmp_pkg::MODE_POW: return (s > (smax >> 8)) ? smax : (s << 8);
      fbmp_pkg::MODE_POW_N: begin
        if (sh <= 8) return (s > (smax >> (8 - sh))) ? smax : (s << (8 - sh));
        return (s + (64'd1 << (sh - 9))) >> (sh - 8);
      end
      fbmp_pkg::MODE_DB: begin
        norm = longint'($signed(dbp_norm));
        flo = longint'($signed(min_dbp));
        if (flo < norm - fbmp_pkg::DB_SPAN) flo = norm - fbmp_pkg::DB_SPAN;
        if (s == 0) begin
          v = flo;
        end else begin
          t = longint'(log2_fix(s)) - longint'(sh) * 65536;
          u = t * fbmp_pkg::DB_PER_LOG2 + (64'd1 << 40) + (64'd1 << 23);
          v = norm + (longint'(u >> 24) - 65536);
          if (v < flo) v = flo;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return fbmp_pkg::SPEC_W'(v);
      end
      default: return '0;
    endcase
  endfunction

  function automatic bin_result_t bin_result(int bin, longint x, longint y, bit dc_or_ny,
                                             int l2, bit fend, bit rend);
    bin_result_t r;
    logic [2:0] mode = mag_mode;
    bit [63:0] ax = (x < 0) ? -x : x, ay = (y < 0) ? -y : y;
    if (mode > fbmp_pkg::MODE_DB) mode = fbmp_pkg::MODE_OFF;
    if (mode == fbmp_pkg::MODE_OFF && !phase_en) mode = fbmp_pkg::MODE_MAG;
    r.bin = 12'(bin);
    r.spec = level_of(ax * ax + ay * ay, mode, l2);
    if (!phase_en) r.phase = '0;
    else if (dc_or_ny) r.phase = (x >= 0) ? 16'd0 : fbmp_pkg::PI_Q13;
    else r.phase = bin_angle(x, y);
    r.fend = fend;
    r.rend = rend;
    return r;
  endfunction

  task automatic predict_pair(int a, int b);
    int l2 = frame_log2;
    int half;
    if (l2 < 2) l2 = 2;
    if (l2 > 12) l2 = 12;
    half = 1 << (l2 - 1);
    if (pair_cnt == 0) begin
      held_nyquist = 24'(b);
      bin_results_q.push_back(bin_result(0, a, 0, 1'b1, l2, 1'b0, 1'b1));
      pair_cnt = 11'd1;
    end else if (pair_cnt >= half - 1) begin
      bin_results_q.push_back(bin_result(pair_cnt, a, b, 1'b0, l2, 1'b0, 1'b0));
      bin_results_q.push_back(bin_result(half, longint'($signed(held_nyquist)), 0, 1'b1, l2,
                                         1'b1, 1'b1));
      pair_cnt = '0;
    end else begin
      bin_results_q.push_back(bin_result(pair_cnt, a, b, 1'b0, l2, 1'b0, 1'b1));
      pair_cnt++;
    end
  endtask

  task automatic send_pair(int a, int b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_first_value <= 24'(a);
    in_second_value <= 24'(b);
    do @(posedge clk); while (in_full);
    predict_pair(a, b);
    items_sent++;
  endtask

  task automatic write_reg(fbmp_pkg::cfg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fbmp_pkg::CFG_FRAME_LOG2: frame_log2 = 4'(value);
      fbmp_pkg::CFG_MAG_MODE: mag_mode = 3'(value);
      fbmp_pkg::CFG_PHASE_EN: phase_en = 1'(value);
      fbmp_pkg::CFG_DBP_NORM: dbp_norm = 16'(value);
      fbmp_pkg::CFG_MIN_DBP: min_dbp = 16'(value);
      default: ;
    endcase
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (bin_results_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic int sample_val();
    case ($urandom_range(0, 5))
      0: return -8388608;
      1: return 8388607;
      2: return $urandom_range(0, 30) - 15;
      default: return $signed(24'($urandom()));
    endcase
  endfunction

  initial begin
    forever begin
      out_pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (bin_results_q.size() == 0) begin
          $display("%0t: unexpected result, exp none act bin %0d", $time, out_bin_index);
          errors++;
        end else begin
          bin_result_t e;
          e = bin_results_q.pop_front();
          if (out_bin_index !== e.bin || out_spectral_value !== e.spec ||
              out_phase_angle !== e.phase || out_frame_end !== e.fend ||
              out_run_end !== e.rend) begin
            $display("%0t: mismatch exp bin %0d val %h ph %h fe %b re %b", $time, e.bin,
                     e.spec, e.phase, e.fend, e.rend);
            $display("%0t:          act bin %0d val %h ph %h fe %b re %b", $time,
                     out_bin_index, out_spectral_value, out_phase_angle, out_frame_end,
                     out_run_end);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (items_sent >= 300);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t rows[$] = '{
      '{-8388608, 8388607, 1'b1, 64'd2147483648}, '{8388607, -8388608, 1'b0, 0},
      '{0, 0, 1'b1, 0}, '{-8388608, -8388608, 1'b0, 0}, '{8388607, 8388607, 1'b0, 0},
      '{3, 4, 1'b1, 1280}, '{-1, 0, 1'b1, 256}, '{0, -1, 1'b1, 256},
      '{1, 1, 1'b0, 0}, '{-5, 12, 1'b1, 3328}, '{100, -7, 1'b0, 0}
    };
    setting_t plan[$] = '{
      '{2, fbmp_pkg::MODE_MAG, 1, 0, -32768, 90}, '{3, fbmp_pkg::MODE_MAG_N, 1, 0, 0, 90},
      '{12, fbmp_pkg::MODE_MAG_N, 0, 0, 0, 30}, '{2, fbmp_pkg::MODE_POW, 1, 0, 0, 90},
      '{4, fbmp_pkg::MODE_POW_N, 1, 0, 0, 90}, '{12, fbmp_pkg::MODE_POW_N, 0, 0, 0, 30},
      '{3, fbmp_pkg::MODE_DB, 1, 23117, -26112, 90},
      '{2, fbmp_pkg::MODE_DB, 0, 32767, 32767, 90},
      '{5, fbmp_pkg::MODE_DB, 1, -32768, -32768, 90}, '{0, fbmp_pkg::MODE_OFF, 0, 0, 0, 90},
      '{15, fbmp_pkg::MODE_OFF, 1, 0, 0, 40}, '{1, fbmp_pkg::mode_t'(3'd6), 1, 0, 0, 90},
      '{13, fbmp_pkg::mode_t'(3'd7), 0, 0, 0, 40},
      '{2, fbmp_pkg::MODE_DB, 1, -100, 5000, 90},
      '{3, fbmp_pkg::MODE_POW, 0, 0, 0, 90}
    };
    frame_log2 = fbmp_pkg::RST_FRAME_LOG2;
    mag_mode = fbmp_pkg::RST_MAG_MODE;
    phase_en = fbmp_pkg::RST_PHASE_EN;
    dbp_norm = fbmp_pkg::RST_DBP_NORM;
    min_dbp = fbmp_pkg::RST_MIN_DBP;
    pair_cnt = '0;
    held_nyquist = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_pair(rows[i].a, rows[i].b);
      if (rows[i].lit) begin
        bin_results_q[bin_results_q.size() - 1].spec = fbmp_pkg::SPEC_W'(rows[i].spec);
      end
    end
    drain();
    foreach (plan[p]) begin
      tx_idle_pct = (p < 5) ? 13 : (p < 10) ? 69 : 0;
      rx_idle_pct = (p < 5) ? 69 : (p < 10) ? 13 : 0;
      write_reg(fbmp_pkg::CFG_FRAME_LOG2, plan[p].log2n);
      write_reg(fbmp_pkg::CFG_MAG_MODE, plan[p].mode);
      write_reg(fbmp_pkg::CFG_PHASE_EN, plan[p].ph);
      write_reg(fbmp_pkg::CFG_DBP_NORM, plan[p].norm);
      write_reg(fbmp_pkg::CFG_MIN_DBP, plan[p].floor_db);
      cfg_valid <= 1'b0;
      repeat (plan[p].items) send_pair(sample_val(), sample_val());
      drain();
    end
    if (errors == 0 && bin_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
